// ----- rtl/core/mfpq_pkg.sv -----
package mfpq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned FILL_W   = 5;
  localparam int unsigned ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic need_pass;
    logic pass_last;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/core/mfpq_ctrl.sv -----
module mfpq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mfpq_pkg::sts_t   sts_i,
  output mfpq_pkg::cmd_t   cmd_o
);
  import mfpq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.need_pass ? ST_PASS : ST_DONE;
        end
      end
      ST_PASS: begin
        if (sts_i.pass_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.accept  = in_valid_i;
      end
      ST_PASS: begin
        cmd_o.step = 1'b1;
      end
      ST_DONE: begin
        cmd_o.load = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  a_pass_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PASS && sts_i.pass_last) |=> (state_q == ST_DONE))
    else $error("pass did not finish into done");

endmodule

// ----- rtl/core/mfpq_dpath.sv -----
module mfpq_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mfpq_pkg::cmd_t                cmd_i,
  output mfpq_pkg::sts_t                sts_o,
  input  logic                          func_i,
  input  logic [mfpq_pkg::ID_W-1:0]     entry_id_i,
  input  logic [mfpq_pkg::PRIO_W-1:0]   entry_priority_i,
  input  logic                          ordered_insert_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic                          out_valid_o,
  output logic [mfpq_pkg::ID_W-1:0]     out_id_o,
  output logic [mfpq_pkg::PRIO_W-1:0]   out_priority_o,
  output logic                          overflow_o,
  output logic                          is_empty_o,
  output logic [mfpq_pkg::FILL_W-1:0]   fill_level_o
);
  import mfpq_pkg::*;

  entry_t slots [CAPACITY];

  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  idx_q;
  logic [CNT_W-1:0]  idx_nxt;
  logic              op_q;
  logic              found_q;
  logic              hit_q;
  logic              ovf_q;
  entry_t            new_q;
  entry_t            carry_q;
  entry_t            head_q;
  entry_t            rd_data_q;

  logic              full;
  logic              do_append;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;

  logic              res_valid_q;
  logic              out_valid_q;
  logic              ovf_res_q;
  logic              empty_res_q;
  entry_t            out_q;
  logic [FILL_W-1:0] fill_q;

  assign full    = (count_q == CNT_W'(CAPACITY));
  assign idx_nxt = idx_q + CNT_W'(1);

  // unordered enqueue into a non-full store writes the tail at once
  assign do_append = cmd_i.accept && (func_i == FUNC_ENQ) && !full && !ordered_insert_i;

  always_comb begin
    sts_o.need_pass = (func_i == FUNC_ENQ) ? (!full && ordered_insert_i) : (count_q != '0);
    if (op_q == FUNC_ENQ) begin
      sts_o.pass_last = (idx_q == count_q);
    end else begin
      sts_o.pass_last = (idx_q == count_q - CNT_W'(1));
    end
    sts_o.out_free = !res_valid_q || res_ready_i;
  end

  // read ahead by one element; data of slot idx_q sits in rd_data_q
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd_i.accept) begin
      rd_en = sts_o.need_pass;
    end else if (cmd_i.step) begin
      rd_en   = (idx_nxt < count_q);
      rd_addr = idx_nxt[ADDR_W-1:0];
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q[ADDR_W-1:0];
    wr_data = new_q;
    if (do_append) begin
      wr_en   = 1'b1;
      wr_addr = count_q[ADDR_W-1:0];
      wr_data = '{id: entry_id_i, prio: entry_priority_i};
    end else if (cmd_i.step) begin
      if (op_q == FUNC_ENQ) begin
        if (idx_q == count_q) begin
          wr_en   = 1'b1;
          wr_data = found_q ? carry_q : new_q;
        end else if (found_q) begin
          wr_en   = 1'b1;
          wr_data = carry_q;
        end else if (rd_data_q.prio > new_q.prio) begin
          wr_en   = 1'b1;
          wr_data = new_q;
        end
      end else if (idx_q != '0) begin
        wr_en   = 1'b1;
        wr_addr = idx_q[ADDR_W-1:0] - ADDR_W'(1);
        wr_data = rd_data_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slots[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= slots[rd_addr];
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_append) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.step && sts_o.pass_last) begin
      count_d = (op_q == FUNC_ENQ) ? count_q + CNT_W'(1) : count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // per-transaction working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q    <= func_i;
      new_q   <= '{id: entry_id_i, prio: entry_priority_i};
      ovf_q   <= (func_i == FUNC_ENQ) && full;
      hit_q   <= 1'b0;
      found_q <= 1'b0;
      idx_q   <= '0;
    end else if (cmd_i.step) begin
      idx_q <= idx_nxt;
      if (op_q == FUNC_ENQ) begin
        if (idx_q != count_q && (found_q || rd_data_q.prio > new_q.prio)) begin
          found_q <= 1'b1;
          carry_q <= rd_data_q;
        end
      end else if (idx_q == '0) begin
        head_q <= rd_data_q;
        hit_q  <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_valid_q <= hit_q;
      out_q       <= hit_q ? head_q : '0;
      ovf_res_q   <= ovf_q;
      empty_res_q <= (count_q == '0);
      fill_q      <= FILL_W'(count_q);
    end
  end

  assign res_valid_o    = res_valid_q;
  assign out_valid_o    = out_valid_q;
  assign out_id_o       = out_q.id;
  assign out_priority_o = out_q.prio;
  assign overflow_o     = ovf_res_q;
  assign is_empty_o     = empty_res_q;
  assign fill_level_o   = fill_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!res_valid_q || res_ready_i))
    else $error("result register overwritten");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (idx_q <= count_q))
    else $error("pass index beyond fill");

  a_res_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> !(out_valid_q && ovf_res_q))
    else $error("dequeue result flagged overflow");

endmodule

// ----- rtl/core/mixed_fifo_priority_queue.sv -----
// mixed_fifo_priority_queue: list of (id, priority) entries, head served first
//
// input channel (in_valid_i / in_ready_o) carries one operation per transaction:
//   func_i = 0 enqueues entry_id_i / entry_priority_i, appended at the tail, or
//   with ordered_insert_i = 1 placed before the first entry of larger value
//   func_i = 1 removes the head entry
// result channel (res_valid_o / res_ready_i) returns one result per transaction
// with the dequeued entry, overflow flag, empty flag and fill level
//
// full-store enqueue, empty dequeue and unordered enqueue go from acceptance
// straight to the result load; ordered enqueue and dequeue first make one forward
// pass over the entry memory, one step per held entry (plus one for the tail on
// enqueue), at most one slot read and one slot written per cycle; the result
// turns valid in the same cycle that the next transaction can be taken
// one transaction is processed at a time; the next is taken once the previous
// result sits in the output register, while that result still waits
// a stalled receiver holds the result; the block then finishes the operation
// in progress and waits before loading the next result
// reset empties the queue at once; entry memory contents are not cleared
module mixed_fifo_priority_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [mfpq_pkg::ID_W-1:0]     entry_id_i,
  input  logic [mfpq_pkg::PRIO_W-1:0]   entry_priority_i,
  input  logic                          ordered_insert_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic                          out_valid_o,
  output logic [mfpq_pkg::ID_W-1:0]     out_id_o,
  output logic [mfpq_pkg::PRIO_W-1:0]   out_priority_o,
  output logic                          overflow_o,
  output logic                          is_empty_o,
  output logic [mfpq_pkg::FILL_W-1:0]   fill_level_o
);
  import mfpq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mfpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mfpq_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .func_i           (func_i),
    .entry_id_i       (entry_id_i),
    .entry_priority_i (entry_priority_i),
    .ordered_insert_i (ordered_insert_i),
    .res_valid_o      (res_valid_o),
    .res_ready_i      (res_ready_i),
    .out_valid_o      (out_valid_o),
    .out_id_o         (out_id_o),
    .out_priority_o   (out_priority_o),
    .overflow_o       (overflow_o),
    .is_empty_o       (is_empty_o),
    .fill_level_o     (fill_level_o)
  );

endmodule
